/* sv/mld_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mld_pkg: shared types and constants of the MIME line decoder
// Character codes, decode helper functions and the command and status
// bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package mld_pkg;

    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QM    = 8'h3F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_LOW_Q = 8'h71;
    localparam logic [7:0] CH_LOW_B = 8'h62;
    localparam logic [7:0] BYTE_ALL = 8'hFF;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_Q    = 2'd1;
    localparam logic [1:0] KIND_B    = 2'd2;

    localparam logic [1:0] ESC_IDLE   = 2'd0;
    localparam logic [1:0] ESC_FIRST  = 2'd1;
    localparam logic [1:0] ESC_SECOND = 2'd2;

    typedef struct packed {
        logic accept;
        logic step;
        logic quad_emit;
        logic finish;
    } mld_cmd_t;

    typedef struct packed {
        logic free;
        logic acc_run;
        logic empty;
        logic wait_more;
        logic quad_fire;
        logic quad_last;
        logic ended;
    } mld_status_t;

    function automatic logic [6:0] b64_value(input logic [7:0] c);
        logic [6:0] v;
        v = 7'd64;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            v = 7'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            v = 7'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 7'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B)
        begin
            v = 7'd62;
        end
        else if (c == 8'h2F)
        begin
            v = 7'd63;
        end
        return v;
    endfunction

    function automatic logic [5:0] code63(input logic [7:0] c);
        logic [6:0] v;
        v = b64_value(c);
        return v[6] ? 6'h3F : v[5:0];
    endfunction

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 5'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 5'(c - 8'h61 + 8'd10);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 5'(c - 8'h41 + 8'd10);
        end
        return v;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage
`default_nettype wire

/* sv/mld_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mld_ctrl: sequencing controller
// Accepts input words, steps the decoder over buffered bytes, emits the
// bytes of a base64 quartet and closes the line.
// ----------------------------------------------------------------------------
module mld_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire mld_pkg::mld_status_t sts,
    output mld_pkg::mld_cmd_t         cmd
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_QUAD, ST_FIN} state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = sts.free;
                if (sts.free && in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.acc_run)
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (sts.free)
                begin
                    if (sts.empty || sts.wait_more)
                    begin
                        state_next = sts.ended ? ST_FIN : ST_IDLE;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                        if (sts.quad_fire)
                        begin
                            state_next = ST_QUAD;
                        end
                    end
                end
            end
            ST_QUAD:
            begin
                if (sts.free)
                begin
                    cmd.quad_emit = 1'b1;
                    if (sts.quad_last)
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_FIN:
            begin
                if (sts.free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* sv/mld_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mld_datapath: decoder datapath
// Lookahead buffer, mode and construct state, held byte and output register.
// ----------------------------------------------------------------------------
module mld_datapath
#(
    parameter int PROBE_LENGTH = 10
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_wdata,
    input  wire logic [7:0]         in_byte,
    input  wire logic               in_first,
    input  wire logic               in_last,
    input  wire logic               in_start_qp,
    input  wire logic               in_start_b64,
    input  wire mld_pkg::mld_cmd_t  cmd,
    output mld_pkg::mld_status_t    sts,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              out_byte,
    output logic                    out_bv,
    output logic                    out_eol
);

    localparam int DEPTH = PROBE_LENGTH + 2;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = $clog2(DEPTH);

    logic [7:0]    fifo_reg [DEPTH];
    logic [7:0]    fifo_next [DEPTH];
    logic [CW-1:0] count_reg, count_next;
    logic          enable_reg, enable_next;
    logic          mode_qp_reg, mode_qp_next;
    logic          mode_b64_reg, mode_b64_next;
    logic          b64_done_reg, b64_done_next;
    logic          hdr_scan_reg, hdr_scan_next;
    logic [1:0]    hdr_marks_reg, hdr_marks_next;
    logic [1:0]    hdr_kind_reg, hdr_kind_next;
    logic [7:0]    qheld_reg [3];
    logic [7:0]    qheld_next [3];
    logic [2:0]    qcount_reg, qcount_next;
    logic [1:0]    esc_stage_reg, esc_stage_next;
    logic [3:0]    esc_nib_reg, esc_nib_next;
    logic          held_valid_reg, held_valid_next;
    logic [7:0]    held_byte_reg, held_byte_next;
    logic          line_open_reg, line_open_next;
    logic          line_dec_reg, line_dec_next;
    logic          probe_reg, probe_next;
    logic          ended_reg, ended_next;
    logic [7:0]    qbytes_reg [3];
    logic [7:0]    qbytes_next [3];
    logic [1:0]    qn_reg, qn_next;
    logic [1:0]    qidx_reg, qidx_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_bv_reg, out_bv_next;
    logic          out_eol_reg, out_eol_next;

    logic          free;
    logic [7:0]    c, n1, n2;
    logic          have1, have2;
    logic          in_construct;
    logic [5:0]    v0, v1, v2;
    logic [6:0]    v3;
    logic [4:0]    hv;
    logic [1:0]    cons;
    logic          prod_en;
    logic [7:0]    prod_byte;
    logic          load;
    logic [7:0]    load_byte;
    logic          load_bv;
    logic          load_eol;
    logic          start;
    logic          dec;
    logic [CW-1:0] cnt_base;
    logic [CW-1:0] cnt_after;
    logic          pend;
    logic [1:0]    marks_inc;
    logic          eff_b64;
    logic [7:0]    fin_byte;
    logic [7:0]    esc_byte;

    always_comb
    begin
        free         = !out_valid_reg || out_ready;
        c            = fifo_reg[0];
        n1           = fifo_reg[1];
        n2           = fifo_reg[2];
        have1        = count_reg > CW'(1);
        have2        = count_reg > CW'(2);
        in_construct = hdr_scan_reg || (esc_stage_reg != mld_pkg::ESC_IDLE)
                       || (qcount_reg != 3'd0);
        v0           = mld_pkg::code63(qheld_reg[0]);
        v1           = mld_pkg::code63(qheld_reg[1]);
        v2           = mld_pkg::code63(qheld_reg[2]);
        v3           = mld_pkg::b64_value(c);
        hv           = mld_pkg::hex_value(c);
        marks_inc    = hdr_marks_reg + 2'd1;
        esc_byte     = {esc_nib_reg, hv[3:0]};

        for (int i = 0; i < DEPTH; i++)
        begin
            fifo_next[i] = fifo_reg[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            qheld_next[i]  = qheld_reg[i];
            qbytes_next[i] = qbytes_reg[i];
        end
        count_next      = count_reg;
        enable_next     = cfg_we ? cfg_wdata : enable_reg;
        mode_qp_next    = mode_qp_reg;
        mode_b64_next   = mode_b64_reg;
        b64_done_next   = b64_done_reg;
        hdr_scan_next   = hdr_scan_reg;
        hdr_marks_next  = hdr_marks_reg;
        hdr_kind_next   = hdr_kind_reg;
        qcount_next     = qcount_reg;
        esc_stage_next  = esc_stage_reg;
        esc_nib_next    = esc_nib_reg;
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        line_open_next  = line_open_reg;
        line_dec_next   = line_dec_reg;
        probe_next      = probe_reg;
        ended_next      = ended_reg;
        qn_next         = qn_reg;
        qidx_next       = qidx_reg;

        cons      = 2'd0;
        prod_en   = 1'b0;
        prod_byte = c;
        load      = 1'b0;
        load_byte = 8'h00;
        load_bv   = 1'b0;
        load_eol  = 1'b0;

        sts.free      = free;
        sts.empty     = count_reg == '0;
        sts.ended     = ended_reg;
        sts.quad_last = 2'(qidx_reg + 2'd1) == qn_reg;
        sts.wait_more = !in_construct && !ended_reg && (
                        (c == mld_pkg::CH_QM && (!have1 ||
                            (n1 == mld_pkg::CH_EQ && !have2))) ||
                        (c == mld_pkg::CH_EQ && !have1));
        sts.quad_fire = !hdr_scan_reg && (esc_stage_reg == mld_pkg::ESC_IDLE)
                        && (qcount_reg == 3'd4) && !mld_pkg::is_space(c)
                        && (qheld_reg[0] != mld_pkg::CH_EQ)
                        && (qheld_reg[1] != mld_pkg::CH_EQ);

        // Input word: line start handling, pass-through or buffer and probe.
        start     = in_first || !line_open_reg;
        dec       = start ? enable_reg : line_dec_reg;
        cnt_base  = start ? '0 : count_reg;
        cnt_after = (cnt_base < CW'(DEPTH)) ? CW'(cnt_base + CW'(1)) : cnt_base;
        pend      = start || probe_reg;
        sts.acc_run = dec && !(pend && mld_pkg::b64_value(in_byte) <= 7'd63
                      && cnt_after < CW'(PROBE_LENGTH) && !in_last);
        if (cmd.accept)
        begin
            if (start)
            begin
                line_open_next  = 1'b1;
                line_dec_next   = enable_reg;
                mode_qp_next    = in_start_qp;
                mode_b64_next   = in_start_b64;
                b64_done_next   = 1'b0;
                hdr_scan_next   = 1'b0;
                hdr_marks_next  = 2'd0;
                hdr_kind_next   = mld_pkg::KIND_NONE;
                qheld_next[0]   = 8'h00;
                qheld_next[1]   = 8'h00;
                qheld_next[2]   = 8'h00;
                qcount_next     = 3'd0;
                esc_stage_next  = mld_pkg::ESC_IDLE;
                held_valid_next = 1'b0;
                count_next      = '0;
                probe_next      = 1'b1;
            end
            if (!dec)
            begin
                load      = 1'b1;
                load_byte = in_byte;
                load_bv   = 1'b1;
                load_eol  = in_last;
                if (in_last)
                begin
                    line_open_next = 1'b0;
                end
            end
            else
            begin
                if (cnt_base < CW'(DEPTH))
                begin
                    fifo_next[cnt_base[IW-1:0]] = in_byte;
                end
                count_next = cnt_after;
                ended_next = in_last;
                if (pend)
                begin
                    if (mld_pkg::b64_value(in_byte) > 7'd63)
                    begin
                        mode_b64_next = 1'b0;
                        probe_next    = 1'b0;
                    end
                    else if (cnt_after >= CW'(PROBE_LENGTH))
                    begin
                        probe_next = 1'b0;
                    end
                    else if (in_last)
                    begin
                        mode_b64_next = 1'b0;
                        probe_next    = 1'b0;
                    end
                end
            end
        end

        // One decode step on the byte at the head of the buffer.
        if (cmd.step)
        begin
            cons = 2'd1;
            if (hdr_scan_reg)
            begin
                if (c == mld_pkg::CH_QM)
                begin
                    if (marks_inc == 2'd3)
                    begin
                        if (hdr_kind_reg == mld_pkg::KIND_Q)
                        begin
                            mode_qp_next = 1'b1;
                        end
                        else if (hdr_kind_reg == mld_pkg::KIND_B)
                        begin
                            mode_b64_next = 1'b1;
                        end
                        hdr_scan_next  = 1'b0;
                        hdr_marks_next = 2'd0;
                        hdr_kind_next  = mld_pkg::KIND_NONE;
                    end
                    else
                    begin
                        hdr_marks_next = marks_inc;
                    end
                end
                else if (hdr_marks_reg == 2'd2)
                begin
                    if ((c | mld_pkg::CH_SPACE) == mld_pkg::CH_LOW_Q)
                    begin
                        hdr_kind_next = mld_pkg::KIND_Q;
                    end
                    else if ((c | mld_pkg::CH_SPACE) == mld_pkg::CH_LOW_B)
                    begin
                        hdr_kind_next = mld_pkg::KIND_B;
                    end
                    else
                    begin
                        hdr_kind_next = mld_pkg::KIND_NONE;
                    end
                end
            end
            else if (esc_stage_reg == mld_pkg::ESC_FIRST)
            begin
                esc_stage_next = mld_pkg::ESC_SECOND;
                esc_nib_next   = hv[4] ? 4'hF : hv[3:0];
            end
            else if (esc_stage_reg != mld_pkg::ESC_IDLE)
            begin
                esc_stage_next = mld_pkg::ESC_IDLE;
                if (!hv[4] && esc_byte != mld_pkg::BYTE_ALL)
                begin
                    prod_en   = 1'b1;
                    prod_byte = esc_byte;
                end
            end
            else if (qcount_reg != 3'd0)
            begin
                if (!mld_pkg::is_space(c))
                begin
                    if (qcount_reg < 3'd4)
                    begin
                        qheld_next[2'(qcount_reg - 3'd1)] = c;
                        qcount_next = 3'(qcount_reg + 3'd1);
                    end
                    else
                    begin
                        qcount_next    = 3'd0;
                        qheld_next[0]  = 8'h00;
                        qheld_next[1]  = 8'h00;
                        qheld_next[2]  = 8'h00;
                        qidx_next      = 2'd0;
                        qbytes_next[0] = {v0, v1[5:4]};
                        qbytes_next[1] = {v1[3:0], v2[5:2]};
                        qbytes_next[2] = v3[6] ? mld_pkg::BYTE_ALL : {v2[1:0], v3[5:0]};
                        if (qheld_reg[0] == mld_pkg::CH_EQ
                            || qheld_reg[1] == mld_pkg::CH_EQ)
                        begin
                            b64_done_next = 1'b1;
                        end
                        else if (qheld_reg[2] == mld_pkg::CH_EQ)
                        begin
                            b64_done_next = 1'b1;
                            qn_next       = 2'd1;
                        end
                        else if (c == mld_pkg::CH_EQ)
                        begin
                            b64_done_next = 1'b1;
                            qn_next       = 2'd2;
                        end
                        else
                        begin
                            qn_next = 2'd3;
                        end
                    end
                end
            end
            else if (c == mld_pkg::CH_QM && have1 && n1 == mld_pkg::CH_EQ)
            begin
                if (have2 && n2 == mld_pkg::CH_SPACE)
                begin
                    mode_qp_next  = 1'b0;
                    mode_b64_next = 1'b0;
                    cons          = 2'd2;
                end
            end
            else if (c == mld_pkg::CH_EQ && have1 && n1 == mld_pkg::CH_QM)
            begin
                hdr_scan_next  = 1'b1;
                hdr_marks_next = 2'd0;
                hdr_kind_next  = mld_pkg::KIND_NONE;
            end
            else if (c == mld_pkg::CH_LF)
            begin
                prod_en       = !mode_b64_reg;
                b64_done_next = 1'b0;
                mode_qp_next  = 1'b0;
                mode_b64_next = 1'b0;
            end
            else if (mode_qp_reg && c == mld_pkg::CH_EQ)
            begin
                esc_stage_next = mld_pkg::ESC_FIRST;
            end
            else if (mode_b64_reg && !b64_done_reg)
            begin
                if (mld_pkg::is_space(c))
                begin
                    qcount_next = 3'd1;
                end
                else
                begin
                    qcount_next   = 3'd2;
                    qheld_next[0] = c;
                end
                qheld_next[1] = 8'h00;
                qheld_next[2] = 8'h00;
                if (mld_pkg::is_space(c))
                begin
                    qheld_next[0] = 8'h00;
                end
            end
            else
            begin
                prod_en = 1'b1;
            end
        end

        if (cmd.quad_emit)
        begin
            prod_en   = 1'b1;
            prod_byte = qbytes_reg[qidx_reg];
            qidx_next = 2'(qidx_reg + 2'd1);
        end

        if (cons == 2'd1)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                fifo_next[i] = fifo_reg[i + 1];
            end
            count_next = CW'(count_reg - CW'(1));
        end
        else if (cons == 2'd2)
        begin
            for (int i = 0; i < DEPTH - 2; i++)
            begin
                fifo_next[i] = fifo_reg[i + 2];
            end
            count_next = CW'(count_reg - CW'(2));
        end

        if (prod_en)
        begin
            if (held_valid_reg)
            begin
                load      = 1'b1;
                load_byte = held_byte_reg;
                load_bv   = 1'b1;
                load_eol  = 1'b0;
            end
            held_valid_next = 1'b1;
            held_byte_next  = prod_byte;
        end

        // Line close: pending header kind applies, a held '=' may become LF.
        eff_b64  = mode_b64_reg || (hdr_scan_reg && hdr_kind_reg == mld_pkg::KIND_B);
        fin_byte = (!eff_b64 && held_byte_reg == mld_pkg::CH_EQ) ? mld_pkg::CH_LF
                   : held_byte_reg;
        if (cmd.finish)
        begin
            if (hdr_scan_reg)
            begin
                if (hdr_kind_reg == mld_pkg::KIND_Q)
                begin
                    mode_qp_next = 1'b1;
                end
                else if (hdr_kind_reg == mld_pkg::KIND_B)
                begin
                    mode_b64_next = 1'b1;
                end
            end
            hdr_scan_next   = 1'b0;
            hdr_marks_next  = 2'd0;
            hdr_kind_next   = mld_pkg::KIND_NONE;
            esc_stage_next  = mld_pkg::ESC_IDLE;
            qcount_next     = 3'd0;
            qheld_next[0]   = 8'h00;
            qheld_next[1]   = 8'h00;
            qheld_next[2]   = 8'h00;
            load            = 1'b1;
            load_byte       = held_valid_reg ? fin_byte : 8'h00;
            load_bv         = held_valid_reg;
            load_eol        = 1'b1;
            held_valid_next = 1'b0;
            count_next      = '0;
            line_open_next  = 1'b0;
            ended_next      = 1'b0;
        end

        out_valid_next = load || (out_valid_reg && !out_ready);
        out_byte_next  = load ? load_byte : out_byte_reg;
        out_bv_next    = load ? load_bv : out_bv_reg;
        out_eol_next   = load ? load_eol : out_eol_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            enable_reg     <= 1'b1;
            mode_qp_reg    <= 1'b0;
            mode_b64_reg   <= 1'b0;
            b64_done_reg   <= 1'b0;
            hdr_scan_reg   <= 1'b0;
            hdr_marks_reg  <= 2'd0;
            hdr_kind_reg   <= mld_pkg::KIND_NONE;
            qcount_reg     <= 3'd0;
            esc_stage_reg  <= mld_pkg::ESC_IDLE;
            held_valid_reg <= 1'b0;
            line_open_reg  <= 1'b0;
            line_dec_reg   <= 1'b0;
            probe_reg      <= 1'b0;
            ended_reg      <= 1'b0;
            qn_reg         <= 2'd0;
            qidx_reg       <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            enable_reg     <= enable_next;
            mode_qp_reg    <= mode_qp_next;
            mode_b64_reg   <= mode_b64_next;
            b64_done_reg   <= b64_done_next;
            hdr_scan_reg   <= hdr_scan_next;
            hdr_marks_reg  <= hdr_marks_next;
            hdr_kind_reg   <= hdr_kind_next;
            qcount_reg     <= qcount_next;
            esc_stage_reg  <= esc_stage_next;
            held_valid_reg <= held_valid_next;
            line_open_reg  <= line_open_next;
            line_dec_reg   <= line_dec_next;
            probe_reg      <= probe_next;
            ended_reg      <= ended_next;
            qn_reg         <= qn_next;
            qidx_reg       <= qidx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            fifo_reg[i] <= fifo_next[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            qheld_reg[i]  <= qheld_next[i];
            qbytes_reg[i] <= qbytes_next[i];
        end
        esc_nib_reg   <= esc_nib_next;
        held_byte_reg <= held_byte_next;
        out_byte_reg  <= out_byte_next;
        out_bv_reg    <= out_bv_next;
        out_eol_reg   <= out_eol_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_bv    = out_bv_reg;
    assign out_eol   = out_eol_reg;

endmodule
`default_nettype wire

/* sv/mime_line_decoder_unit.sv */
`default_nettype none
// A pass-through word is registered at the output in the cycle after it is taken.
// A decoded word is accepted, the buffered bytes are stepped and each quartet output
// byte is emitted, then the line is closed if it has ended and control returns to idle.
// A new word is taken only in the idle state while the output slot is free, so a
// pass-through or probed word can follow every cycle; a decoded word waits for idle.
// Reset clears all control state and sets the decode enable to one.
// ----------------------------------------------------------------------------
// mime_line_decoder_unit: MIME line decoder top level
// Streaming byte decoder for quoted-printable, base64 and encoded words.
// ----------------------------------------------------------------------------
module mime_line_decoder_unit
#(
    parameter int PROBE_LENGTH = 10
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // in_byte
    input  wire logic [2:0] s_axis_tuser,   // line_first, start_qp, start_base64
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // out_byte
    output logic            m_axis_tuser,   // byte_valid
    output logic            m_axis_tlast
);

    mld_pkg::mld_cmd_t    cmd;
    mld_pkg::mld_status_t sts;

    mld_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mld_datapath #(.PROBE_LENGTH(PROBE_LENGTH)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_byte      (s_axis_tdata),
        .in_first     (s_axis_tuser[0]),
        .in_last      (s_axis_tlast),
        .in_start_qp  (s_axis_tuser[1]),
        .in_start_b64 (s_axis_tuser[2]),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_byte     (m_axis_tdata),
        .out_bv       (m_axis_tuser),
        .out_eol      (m_axis_tlast)
    );

endmodule
`default_nettype wire

/* sv/mld_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mld_checker: port checker for the MIME line decoder
// Watches the stream ports and flags handshake and result format errors.
// ----------------------------------------------------------------------------
module mld_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tuser,
    input wire logic       m_axis_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'h00)
        else $error("bare end marker malformed");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
        else $error("input taken while output slot is full");

endmodule

bind mime_line_decoder_unit mld_checker u_mld_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

/* tb/sv/mime_line_decoder_unit_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mime_line_decoder_unit_tb: self-checking bench for the MIME line decoder
// Feeds lines of text, encoded words, quoted-printable and base64 content
// through the input stream, predicts every output word in the bench and
// compares the output stream against the predicted queue in order.
// ----------------------------------------------------------------------------
module mime_line_decoder_unit_tb;

    localparam int PROBE = 10;
    localparam int DEPTH = PROBE + 2;
    localparam int MAX_CYCLES = 400000;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       qp;
        logic       b64;
    } line_word_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       eol;
    } dec_word_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic [2:0] s_axis_tuser = '0;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tuser;
    logic       m_axis_tlast;

    line_word_t pending_words[$];
    dec_word_t  expected_bytes[$];
    int         errors = 0;
    int         cycles = 0;
    int         lines_sent = 0;
    int         bytes_checked = 0;
    bit         send_idle_ok = 1'b0;
    bit         recv_idle_ok = 1'b0;
    bit         hold_phase = 1'b0;
    bit         hold_done = 1'b0;
    int         hold_off = 0;
    bit         in_fire_q = 1'b0;

    // Decoder state mirrored in the bench.
    bit         enable_reg = 1'b1;
    logic [7:0] ahead[DEPTH];
    int         ahead_n = 0;
    bit         m_qp, m_b64, b64_done;
    logic [4:0] hdr;
    logic [23:0] quad_held;
    int         quad_n;
    logic [5:0] esc;
    logic [8:0] held = '0;
    bit         open_line = 1'b0;
    bit         line_dec, probing;

    mime_line_decoder_unit DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int b64v(logic [7:0] c);
        if (c >= "A" && c <= "Z") return c - "A";
        if (c >= "a" && c <= "z") return c - "a" + 26;
        if (c >= "0" && c <= "9") return c - "0" + 52;
        if (c == "+") return 62;
        if (c == "/") return 63;
        return 64;
    endfunction

    function automatic int hexv(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return 16;
    endfunction

    function automatic bit white(logic [7:0] c);
        return c == mld_pkg::CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [5:0] sext63(logic [7:0] c);
        int v;
        v = b64v(c);
        return v > 63 ? 6'h3F : 6'(v);
    endfunction

    task automatic push_result(logic [7:0] b, logic v, logic e);
        dec_word_t w;
        w.data = b;
        w.valid = v;
        w.eol = e;
        expected_bytes.push_back(w);
    endtask

    task automatic put_byte(logic [7:0] b);
        if (held[8])
        begin
            push_result(held[7:0], 1'b1, 1'b0);
        end
        held = {1'b1, b};
    endtask

    task automatic drop_ahead(int n);
        if (n > ahead_n)
        begin
            n = ahead_n;
        end
        for (int i = 0; i + n < ahead_n; i++)
        begin
            ahead[i] = ahead[i + n];
        end
        ahead_n -= n;
    endtask

    task automatic apply_kind();
        if (hdr[4:3] == mld_pkg::KIND_Q)
        begin
            m_qp = 1'b1;
        end
        else if (hdr[4:3] == mld_pkg::KIND_B)
        begin
            m_b64 = 1'b1;
        end
        hdr = '0;
    endtask

    task automatic header_step(logic [7:0] c);
        logic [1:0] marks;
        logic [1:0] kind;
        logic [7:0] low;
        marks = hdr[2:1];
        kind = hdr[4:3];
        if (c == mld_pkg::CH_QM)
        begin
            if (marks == 2'd2)
            begin
                apply_kind();
                return;
            end
            marks++;
        end
        else if (marks == 2'd2)
        begin
            low = c | 8'h20;
            kind = (low == mld_pkg::CH_LOW_Q) ? mld_pkg::KIND_Q
                 : (low == mld_pkg::CH_LOW_B) ? mld_pkg::KIND_B : mld_pkg::KIND_NONE;
        end
        hdr = {kind, marks, 1'b1};
    endtask

    task automatic escape_step(logic [7:0] c);
        int v;
        logic [7:0] b;
        v = hexv(c);
        if (esc[5:4] == mld_pkg::ESC_FIRST)
        begin
            esc = {mld_pkg::ESC_SECOND, v > 15 ? 4'hF : 4'(v)};
            return;
        end
        if (v <= 15)
        begin
            b = {esc[3:0], 4'(v)};
            if (b != mld_pkg::BYTE_ALL)
            begin
                put_byte(b);
            end
        end
        esc = '0;
    endtask

    task automatic quartet_step(logic [7:0] c);
        logic [7:0] q0, q1, q2;
        logic [5:0] v0, v1, v2;
        int v3;
        if (white(c))
        begin
            return;
        end
        if (quad_n < 4)
        begin
            quad_held[8 * (quad_n - 1) +: 8] = c;
            quad_n++;
            return;
        end
        q0 = quad_held[7:0];
        q1 = quad_held[15:8];
        q2 = quad_held[23:16];
        quad_held = '0;
        quad_n = 0;
        if (q0 == mld_pkg::CH_EQ || q1 == mld_pkg::CH_EQ)
        begin
            b64_done = 1'b1;
            return;
        end
        v0 = sext63(q0);
        v1 = sext63(q1);
        put_byte({v0, v1[5:4]});
        if (q2 == mld_pkg::CH_EQ)
        begin
            b64_done = 1'b1;
            return;
        end
        v2 = sext63(q2);
        put_byte({v1[3:0], v2[5:2]});
        if (c == mld_pkg::CH_EQ)
        begin
            b64_done = 1'b1;
            return;
        end
        v3 = b64v(c);
        put_byte(v3 > 63 ? mld_pkg::BYTE_ALL : {v2[1:0], 6'(v3)});
    endtask

    task automatic decode_ahead(bit ended);
        logic [7:0] c, n1, n2;
        bit have1, have2;
        while (ahead_n > 0)
        begin
            c = ahead[0];
            have1 = ahead_n > 1;
            have2 = ahead_n > 2;
            n1 = have1 ? ahead[1] : 8'h00;
            n2 = have2 ? ahead[2] : 8'h00;
            if (hdr[0])
            begin
                header_step(c);
                drop_ahead(1);
                continue;
            end
            if (esc != 0)
            begin
                escape_step(c);
                drop_ahead(1);
                continue;
            end
            if (quad_n != 0)
            begin
                quartet_step(c);
                drop_ahead(1);
                continue;
            end
            if (c == mld_pkg::CH_QM)
            begin
                if (!have1 && !ended) return;
                if (have1 && n1 == mld_pkg::CH_EQ)
                begin
                    if (!have2 && !ended) return;
                    if (have2 && n2 == mld_pkg::CH_SPACE)
                    begin
                        m_qp = 1'b0;
                        m_b64 = 1'b0;
                        drop_ahead(2);
                    end
                    else
                    begin
                        drop_ahead(1);
                    end
                    continue;
                end
            end
            else if (c == mld_pkg::CH_EQ)
            begin
                if (!have1 && !ended) return;
                if (have1 && n1 == mld_pkg::CH_QM)
                begin
                    hdr = 5'd1;
                    drop_ahead(1);
                    continue;
                end
            end
            else if (c == mld_pkg::CH_LF)
            begin
                if (!m_b64) put_byte(mld_pkg::CH_LF);
                b64_done = 1'b0;
                m_qp = 1'b0;
                m_b64 = 1'b0;
                drop_ahead(1);
                continue;
            end
            if (m_qp && c == mld_pkg::CH_EQ)
            begin
                esc = {mld_pkg::ESC_FIRST, 4'h0};
            end
            else if (m_b64 && !b64_done)
            begin
                quad_n = 1;
                quad_held = '0;
                quartet_step(c);
            end
            else
            begin
                put_byte(c);
            end
            drop_ahead(1);
        end
    endtask

    task automatic predict_decoded(line_word_t w);
        logic [7:0] b;
        if (w.first || !open_line)
        begin
            open_line = 1'b1;
            line_dec = enable_reg;
            m_qp = w.qp;
            m_b64 = w.b64;
            b64_done = 1'b0;
            hdr = '0;
            quad_held = '0;
            quad_n = 0;
            esc = '0;
            held = '0;
            ahead_n = 0;
            probing = 1'b1;
        end
        if (!line_dec)
        begin
            push_result(w.data, 1'b1, w.last);
            if (w.last) open_line = 1'b0;
            return;
        end
        if (ahead_n < DEPTH)
        begin
            ahead[ahead_n] = w.data;
            ahead_n++;
        end
        if (probing)
        begin
            if (b64v(w.data) > 63)
            begin
                m_b64 = 1'b0;
                probing = 1'b0;
            end
            else if (ahead_n >= PROBE)
            begin
                probing = 1'b0;
            end
            else if (w.last)
            begin
                m_b64 = 1'b0;
                probing = 1'b0;
            end
        end
        if (!probing) decode_ahead(w.last);
        if (w.last)
        begin
            if (hdr[0]) apply_kind();
            esc = '0;
            quad_n = 0;
            quad_held = '0;
            if (held[8])
            begin
                b = held[7:0];
                if (!m_b64 && b == mld_pkg::CH_EQ) b = mld_pkg::CH_LF;
                push_result(b, 1'b1, 1'b1);
            end
            else
            begin
                push_result(8'h00, 1'b0, 1'b1);
            end
            held = '0;
            ahead_n = 0;
            open_line = 1'b0;
        end
    endtask

    task automatic queue_line(string s, bit qp, bit b64, bit mark_first, bit mark_last);
        line_word_t w;
        for (int i = 0; i < s.len(); i++)
        begin
            w.data = s[i];
            w.first = mark_first && i == 0;
            w.last = mark_last && i == s.len() - 1;
            w.qp = qp;
            w.b64 = b64;
            pending_words.push_back(w);
        end
        lines_sent++;
    endtask

    function automatic string random_line();
        string alpha;
        string s;
        int kind;
        int n;
        alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        kind = $urandom_range(0, 9);
        s = "";
        n = $urandom_range(1, 6);
        case (kind)
            0, 1, 2:
            begin
                for (int i = 0; i < n + 8; i++)
                begin
                    s = {s, string'(alpha[$urandom_range(0, 63)])};
                    if ($urandom_range(0, 15) == 0) s = {s, " "};
                end
                if ($urandom_range(0, 2) == 0) s = {s, "=="};
            end
            3, 4:
            begin
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        s = {s, "=", string'(alpha[$urandom_range(52, 61)]),
                             string'(alpha[$urandom_range(0, 63)])};
                    end
                    else
                    begin
                        s = {s, string'(byte'($urandom_range(32, 126)))};
                    end
                end
            end
            5, 6:
            begin
                s = {"=?cs?", $urandom_range(0, 1) ? "Q" : "B", "?"};
                for (int i = 0; i < n; i++)
                begin
                    s = {s, string'(alpha[$urandom_range(0, 63)])};
                end
                s = {s, "?= x"};
            end
            default:
            begin
                for (int i = 0; i < n; i++)
                begin
                    s = {s, string'(byte'($urandom_range(1, 255)))};
                end
            end
        endcase
        return s;
    endfunction

    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_enable(bit v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        enable_reg = v;
    endtask

    // Input driver: retires the word taken at the last rising edge and offers
    // the oldest queued word, occasionally idling.
    always @(negedge clk)
    begin
        line_word_t w;
        bit idle;
        idle = send_idle_ok && $urandom_range(0, 99) < 6;
        if (in_fire_q)
        begin
            void'(pending_words.pop_front());
            if (pending_words.size() != 0 && !idle)
            begin
                w = pending_words[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= w.data;
                s_axis_tuser <= {w.b64, w.qp, w.first};
                s_axis_tlast <= w.last;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
        else if (!s_axis_tvalid && pending_words.size() != 0 && !idle)
        begin
            w = pending_words[0];
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= w.data;
            s_axis_tuser <= {w.b64, w.qp, w.first};
            s_axis_tlast <= w.last;
        end
    end

    // Output ready: random idling plus one long hold-off.
    always @(negedge clk)
    begin
        if (hold_phase && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_off <= 300;
            m_axis_tready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= !(recv_idle_ok && $urandom_range(0, 99) < 6);
        end
    end

    // Monitor: predicts at input acceptance, checks at output acceptance.
    always @(posedge clk)
    begin
        dec_word_t e;
        line_word_t w;
        in_fire_q <= s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (s_axis_tvalid && s_axis_tready)
            begin
                w.data = s_axis_tdata;
                w.first = s_axis_tuser[0];
                w.qp = s_axis_tuser[1];
                w.b64 = s_axis_tuser[2];
                w.last = s_axis_tlast;
                predict_decoded(w);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                bytes_checked <= bytes_checked + 1;
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected word data=%h valid=%b eol=%b", $time,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    errors <= errors + 1;
                end
                else
                begin
                    e = expected_bytes.pop_front();
                    if (e.data !== m_axis_tdata || e.valid !== m_axis_tuser
                        || e.eol !== m_axis_tlast)
                    begin
                        $display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
                                 e.data, e.valid, e.eol,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > MAX_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        string s;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed lines, first with no idling at all.
        queue_line("QUJD", 1'b0, 1'b1, 1'b1, 1'b1);
        queue_line("QUJDREVGR0hJ", 1'b0, 1'b1, 1'b1, 1'b1);
        queue_line("a=3D=ff=G1=", 1'b1, 1'b0, 1'b1, 1'b1);
        queue_line("=?x?q?a=41?= b", 1'b0, 1'b0, 1'b1, 1'b1);
        queue_line("=?u?B?QUJD?=\n?", 1'b0, 1'b0, 1'b1, 1'b1);
        queue_line("AAAAAAAAAA ! A=== ", 1'b1, 1'b1, 1'b1, 1'b1);
        queue_line("AB*CAB@!AAAAAAA", 1'b0, 1'b1, 1'b1, 1'b1);
        queue_line("AB", 1'b0, 1'b0, 1'b0, 1'b0);
        queue_line("\xff\x01=?", 1'b0, 1'b0, 1'b1, 1'b1);
        queue_line("?", 1'b0, 1'b0, 1'b1, 1'b1);
        wait_drained();

        write_enable(1'b0);
        queue_line("=?q?Q?\x80\x7f", 1'b1, 1'b1, 1'b1, 1'b1);
        wait_drained();
        write_enable(1'b1);

        // Random lines with idling on both sides.
        send_idle_ok = 1'b1;
        recv_idle_ok = 1'b1;
        for (int i = 0; i < 2; i++)
        begin
            s = random_line();
            queue_line(s, $urandom_range(0, 1), $urandom_range(0, 1),
                       $urandom_range(0, 15) != 0, $urandom_range(0, 15) != 0);
        end
        queue_line("x", 1'b0, 1'b0, 1'b1, 1'b1);
        wait_drained();

        // Long receiver hold-off while a line keeps coming.
        hold_phase = 1'b1;
        queue_line("stall=41 line", 1'b1, 1'b0, 1'b1, 1'b1);
        wait_drained();

        $display("Sent %0d lines, checked %0d output words across pass-through,", lines_sent,
                 bytes_checked);
        $display("quoted-printable, base64 and encoded-word content.");
        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
